// ----- src/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, codes and sizes for the clock frame replacement unit.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int NUM_FRAMES   = 64;
   localparam int PAGE_ID_BITS = 32;
   localparam int FRAME_W      = $clog2(NUM_FRAMES);
   localparam int SWEEP_CNT_W  = $clog2(2 * NUM_FRAMES + 1);
   localparam int GROUP_W      = 8;
   localparam int NUM_GROUPS   = (NUM_FRAMES + GROUP_W - 1) / GROUP_W;

   localparam int CMD_W       = 3;
   localparam int FRAME_SEL_W = 6;
   localparam int STATUS_W    = 2;
   localparam int ACTION_W    = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FRAME = 2'd2;

   localparam logic [ACTION_W-1:0] ACT_SWAP      = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITEBACK = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DROP      = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [PAGE_ID_BITS-1:0] page_id;
      logic [FRAME_SEL_W-1:0]  frame_sel;
      logic                    is_mapped_file;
      logic                    write_access;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [FRAME_SEL_W-1:0]  frame_out;
      logic                    victim_valid;
      logic [PAGE_ID_BITS-1:0] victim_page;
      logic [ACTION_W-1:0]     victim_action;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FREE_PICK,
      S_SWEEP,
      S_VICTIM,
      S_RESULT
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec_simple;
      logic scan_groups;
      logic place_free;
      logic sweep_start;
      logic sweep_step;
      logic victim_read;
      logic victim_commit;
      logic set_no_victim;
      logic load_out;
   } dp_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_alloc;
      logic any_free;
      logic sweep_hit;
      logic sweep_done;
      logic out_free;
   } dp_sts_type;

endpackage

// ----- src/cfr_datapath.sv -----
// ----------------------------------------------------------------------------
// cfr_datapath
// Frame table flags, page store, clock hand, sweep pointer and result
// registers for the clock frame replacement unit.
// ----------------------------------------------------------------------------
module cfr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  cfr_pkg::req_type    req_data,
   input  cfr_pkg::dp_ctl_type ctl,
   output cfr_pkg::dp_sts_type sts,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output cfr_pkg::rsp_type    rsp_data
);

   localparam int NF   = cfr_pkg::NUM_FRAMES;
   localparam int FW   = cfr_pkg::FRAME_W;
   localparam int CW   = cfr_pkg::SWEEP_CNT_W;
   localparam int GW   = cfr_pkg::GROUP_W;
   localparam int NG   = cfr_pkg::NUM_GROUPS;

   cfr_pkg::req_type req_ff;

   logic [NF-1:0] valid_ff,    valid_in;
   logic [NF-1:0] locked_ff,   locked_in;
   logic [NF-1:0] accessed_ff, accessed_in;
   logic [NF-1:0] dirty_ff,    dirty_in;
   logic [NF-1:0] mapped_ff,   mapped_in;

   logic [FW-1:0] hand_ff,  hand_in;
   logic [FW-1:0] pos_ff,   pos_in;
   logic [CW-1:0] count_ff, count_in;

   logic [NG-1:0]    group_free_ff, group_free_in;
   logic [NG*GW-1:0] valid_pad;

   logic [cfr_pkg::PAGE_ID_BITS-1:0] page_mem [NF];
   logic [cfr_pkg::PAGE_ID_BITS-1:0] rd_page_ff;

   cfr_pkg::rsp_type res_ff, res_in;
   cfr_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [FW-1:0] free_idx;
   logic [FW-1:0] sel_idx;
   logic [FW-1:0] pos_next;
   logic [FW-1:0] place_idx;
   logic          place_en;
   logic          sel_in_range;
   logic          sel_hit;
   logic          mem_we;
   logic          out_free;
   int            grp_sel;
   int            bit_sel;

   // frames beyond the table read as taken
   always_comb begin
      valid_pad = '1;
      valid_pad[NF-1:0] = valid_ff;
      for (int g = 0; g < NG; g++) begin
         group_free_in[g] = ~&valid_pad[g*GW +: GW];
      end
   end

   // lowest free frame from the registered group summary
   always_comb begin
      grp_sel = 0;
      bit_sel = 0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (group_free_ff[g]) begin
            grp_sel = g;
         end
      end
      for (int b = GW - 1; b >= 0; b--) begin
         if (!valid_pad[grp_sel*GW + b]) begin
            bit_sel = b;
         end
      end
      free_idx = FW'(grp_sel * GW + bit_sel);
   end

   assign sel_idx      = FW'(req_ff.frame_sel);
   assign sel_in_range = (32'(req_ff.frame_sel) < 32'(NF));
   assign sel_hit      = sel_in_range && valid_ff[sel_idx];
   assign pos_next     = (pos_ff == FW'(NF - 1)) ? '0 : pos_ff + FW'(1);

   assign place_en  = ctl.place_free || ctl.victim_commit;
   assign place_idx = ctl.place_free ? free_idx : pos_ff;
   assign mem_we    = place_en;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sts.is_alloc   = (req_ff.command == cfr_pkg::CMD_ALLOC);
   assign sts.any_free   = |group_free_ff;
   assign sts.sweep_hit  = !locked_ff[pos_ff] && !accessed_ff[pos_ff];
   assign sts.sweep_done = (count_ff == CW'(2 * NF));
   assign sts.out_free   = out_free;

   // flag table and clock state
   always_comb begin
      valid_in    = valid_ff;
      locked_in   = locked_ff;
      accessed_in = accessed_ff;
      dirty_in    = dirty_ff;
      mapped_in   = mapped_ff;
      hand_in     = hand_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;

      if (ctl.exec_simple && sel_hit) begin
         priority case (req_ff.command)
            cfr_pkg::CMD_FREE: begin
               valid_in[sel_idx]    = 1'b0;
               locked_in[sel_idx]   = 1'b0;
               accessed_in[sel_idx] = 1'b0;
               dirty_in[sel_idx]    = 1'b0;
               mapped_in[sel_idx]   = 1'b0;
            end
            cfr_pkg::CMD_TOUCH: begin
               accessed_in[sel_idx] = 1'b1;
               if (req_ff.write_access) begin
                  dirty_in[sel_idx] = 1'b1;
               end
            end
            cfr_pkg::CMD_LOCK: begin
               locked_in[sel_idx] = 1'b1;
            end
            cfr_pkg::CMD_UNLOCK: begin
               locked_in[sel_idx] = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (place_en) begin
         valid_in[place_idx]    = 1'b1;
         locked_in[place_idx]   = 1'b0;
         accessed_in[place_idx] = 1'b0;
         dirty_in[place_idx]    = 1'b0;
         mapped_in[place_idx]   = req_ff.is_mapped_file;
      end

      if (ctl.sweep_start) begin
         pos_in   = hand_ff;
         count_in = '0;
      end

      if (ctl.sweep_step) begin
         // second chance: clear the mark and pass over
         if (!locked_ff[pos_ff]) begin
            accessed_in[pos_ff] = 1'b0;
         end
         pos_in   = pos_next;
         count_in = count_ff + CW'(1);
      end

      if (ctl.victim_commit) begin
         hand_in = pos_next;
      end
   end

   // pending result
   always_comb begin
      res_in = res_ff;
      if (ctl.exec_simple) begin
         res_in = '0;
         if (req_ff.command <= cfr_pkg::CMD_UNLOCK && !sel_hit) begin
            res_in.status = cfr_pkg::ST_BAD_FRAME;
         end else begin
            res_in.status = cfr_pkg::ST_OK;
         end
      end
      if (ctl.place_free) begin
         res_in           = '0;
         res_in.status    = cfr_pkg::ST_OK;
         res_in.frame_out = cfr_pkg::FRAME_SEL_W'(free_idx);
      end
      if (ctl.set_no_victim) begin
         res_in        = '0;
         res_in.status = cfr_pkg::ST_NO_VICTIM;
      end
      if (ctl.victim_commit) begin
         res_in.status       = cfr_pkg::ST_OK;
         res_in.frame_out    = cfr_pkg::FRAME_SEL_W'(pos_ff);
         res_in.victim_valid = 1'b1;
         res_in.victim_page  = rd_page_ff;
         if (!mapped_ff[pos_ff]) begin
            res_in.victim_action = cfr_pkg::ACT_SWAP;
         end else if (dirty_ff[pos_ff]) begin
            res_in.victim_action = cfr_pkg::ACT_WRITEBACK;
         end else begin
            res_in.victim_action = cfr_pkg::ACT_DROP;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         locked_ff    <= '0;
         accessed_ff  <= '0;
         dirty_ff     <= '0;
         mapped_ff    <= '0;
         hand_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         locked_ff    <= locked_in;
         accessed_ff  <= accessed_in;
         dirty_ff     <= dirty_in;
         mapped_ff    <= mapped_in;
         hand_ff      <= hand_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff <= req_data;
      end
      if (ctl.scan_groups) begin
         group_free_ff <= group_free_in;
      end
      res_ff <= res_in;
      if (ctl.load_out) begin
         rsp_ff <= res_ff;
      end
   end

   // page store: one access a cycle, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[place_idx] <= req_ff.page_id;
      end
      if (ctl.victim_read) begin
         rd_page_ff <= page_mem[pos_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/cfr_controller.sv -----
// ----------------------------------------------------------------------------
// cfr_controller
// Command sequencer: decode, free-frame pick, clock sweep, victim write-out
// and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module cfr_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cfr_pkg::dp_sts_type sts,
   output cfr_pkg::dp_ctl_type ctl
);

   cfr_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = (state_ff != cfr_pkg::S_IDLE);

      unique case (state_ff)
         cfr_pkg::S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = cfr_pkg::S_DECODE;
            end
         end
         cfr_pkg::S_DECODE: begin
            if (sts.is_alloc) begin
               ctl.scan_groups = 1'b1;
               state_in        = cfr_pkg::S_FREE_PICK;
            end else begin
               ctl.exec_simple = 1'b1;
               state_in        = cfr_pkg::S_RESULT;
            end
         end
         cfr_pkg::S_FREE_PICK: begin
            if (sts.any_free) begin
               ctl.place_free = 1'b1;
               state_in       = cfr_pkg::S_RESULT;
            end else begin
               ctl.sweep_start = 1'b1;
               state_in        = cfr_pkg::S_SWEEP;
            end
         end
         cfr_pkg::S_SWEEP: begin
            priority if (sts.sweep_done) begin
               ctl.set_no_victim = 1'b1;
               state_in          = cfr_pkg::S_RESULT;
            end else if (sts.sweep_hit) begin
               ctl.victim_read = 1'b1;
               state_in        = cfr_pkg::S_VICTIM;
            end else begin
               ctl.sweep_step = 1'b1;
            end
         end
         cfr_pkg::S_VICTIM: begin
            ctl.victim_commit = 1'b1;
            state_in          = cfr_pkg::S_RESULT;
         end
         cfr_pkg::S_RESULT: begin
            // hold until the output register can take the transfer
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = cfr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfr_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/clock_frame_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// clock_frame_replacement_unit
// Physical frame table with second-chance clock replacement.
// ----------------------------------------------------------------------------
// One command is in flight at a time; a finished result waits in the output
// register while the next command is taken. Free, touch, lock, unlock and the
// unused codes pass through decode and then reach the output register; an
// allocate that finds a free frame first registers a group summary of the valid
// marks, then picks. An allocate on a full table runs the clock sweep, which
// visits one frame per cycle, up to 2 * NUM_FRAMES frames, then reads the
// victim's page and commits; with every frame locked it gives up after
// 2 * NUM_FRAMES frames. The victim's page comes from a single-port page
// store with a registered read. A result that finds the output register still
// stalled waits in the result register, and the next command is taken on
// the cycle after the result moves into the output register.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module clock_frame_replacement_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfr_pkg::rsp_type rsp_data
);

   cfr_pkg::dp_ctl_type ctl;
   cfr_pkg::dp_sts_type sts;

   cfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   cfr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/cfr_checker.sv -----
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks for the clock frame replacement unit.
// ----------------------------------------------------------------------------
module cfr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input cfr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cfr_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one command at a time: busy straight after a transfer in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before the command finished");

   // a reported victim always carries an OK status
   a_victim_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.victim_valid |-> rsp_data.status == cfr_pkg::ST_OK)
      else $error("victim reported with an error status");

   // victim fields are clear when no eviction took place
   a_no_victim_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.victim_valid
         |-> rsp_data.victim_page == '0 && rsp_data.victim_action == cfr_pkg::ACT_SWAP)
      else $error("victim fields set without an eviction");

   // failed commands give no frame
   a_err_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != cfr_pkg::ST_OK |-> rsp_data.frame_out == '0)
      else $error("frame reported on a failed command");

endmodule

bind clock_frame_replacement_unit cfr_checker u_cfr_checker (.*);
